[rtl/sorted_table_binary_search_assert.svh]
// assertion macros for the sorted table search block
// depends on nothing; taken in by files that carry concurrent checks
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define STS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

[rtl/sts_pkg.sv]
// shared types and constants for the sorted table search block
// no dependencies
package sts_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W       = 9;
   localparam int LIM_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int DATA_W      = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [7:0]               entry_index;
      logic signed [DATA_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] position;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

endpackage

[rtl/sts_table_ram.sv]
// table storage: one write port, one read port with registered data
// depends on sts_pkg
module sts_table_ram (
   input  logic                       clock,
   input  sts_pkg::mem_req_type       mem_req,
   output logic [sts_pkg::DATA_W-1:0] rd_data
);

   logic [sts_pkg::DATA_W-1:0] mem [sts_pkg::TABLE_DEPTH];
   logic [sts_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sts_search_ctrl.sv]
// sequencer for table writes and binary search probes
// depends on sts_pkg; drives sts_table_ram through a request struct
module sts_search_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  sts_pkg::req_type           req_item,
   input  logic [sts_pkg::LEN_W-1:0]  active_length,
   input  logic [sts_pkg::DATA_W-1:0] rd_data,
   output logic                       busy,
   output sts_pkg::mem_req_type       mem_req,
   output logic                       rsp_strobe,
   output sts_pkg::rsp_type           rsp_item
);

   sts_pkg::state_type state_ff, state_in;
   logic [sts_pkg::CNT_W-1:0]         lo_ff, lo_in;
   logic [sts_pkg::CNT_W-1:0]         hi_ff, hi_in;
   logic [sts_pkg::IDX_W-1:0]         mid_ff, mid_in;
   logic signed [sts_pkg::DATA_W-1:0] key_ff, key_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sts_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                       accept;
   logic [sts_pkg::LIM_W-1:0]  len_ext;
   logic [sts_pkg::CNT_W-1:0]  hi_start;
   logic [sts_pkg::CNT_W:0]    mid_sum;
   logic signed [sts_pkg::DATA_W-1:0] entry;
   logic                       hit;
   logic                       greater;
   logic [sts_pkg::CNT_W-1:0]  lo_next;
   logic [sts_pkg::CNT_W-1:0]  hi_next;

   assign accept   = start && (state_ff == sts_pkg::ST_IDLE);
   assign len_ext  = sts_pkg::LIM_W'(active_length);
   // saturate the window to the table depth
   assign hi_start = (len_ext > sts_pkg::LIM_W'(sts_pkg::TABLE_DEPTH))
                     ? sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH)
                     : sts_pkg::CNT_W'(len_ext);
   assign entry    = $signed(rd_data);
   assign hit      = (entry == key_ff);
   assign greater  = (entry > key_ff);
   assign lo_next  = greater ? lo_ff : sts_pkg::CNT_W'(mid_ff) + sts_pkg::CNT_W'(1);
   assign hi_next  = greater ? sts_pkg::CNT_W'(mid_ff) : hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      mid_sum       = '0;
      mem_req.we    = 1'b0;
      mem_req.waddr = sts_pkg::IDX_W'(req_item.entry_index);
      mem_req.wdata = req_item.data_value;
      mem_req.raddr = mid_ff;

      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            mid_sum = {1'b0, hi_start};
            mid_in  = sts_pkg::IDX_W'(mid_sum >> 1);
            if (accept) begin
               if (req_item.opcode == sts_pkg::OP_WRITE) begin
                  mem_req.we   = (32'(req_item.entry_index) < 32'(sts_pkg::TABLE_DEPTH));
                  rsp_valid_in = 1'b1;
               end else if (hi_start == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  lo_in         = '0;
                  hi_in         = hi_start;
                  key_in        = req_item.data_value;
                  mem_req.raddr = mid_in;
                  state_in      = sts_pkg::ST_PROBE;
               end
            end
         end
         sts_pkg::ST_PROBE: begin
            mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
            if (hit) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = 8'(mid_ff);
               state_in        = sts_pkg::ST_IDLE;
            end else if (lo_next >= hi_next) begin
               rsp_valid_in = 1'b1;
               state_in     = sts_pkg::ST_IDLE;
            end else begin
               lo_in         = lo_next;
               hi_in         = hi_next;
               mid_in        = sts_pkg::IDX_W'(mid_sum >> 1);
               mem_req.raddr = mid_in;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != sts_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/sorted_table_binary_search.sv]
// top level of the sorted table search block
// depends on sts_pkg, sts_table_ram, sts_search_ctrl and the assertion header
//
// usage
//  - input transfer: start high while busy is low; req_item carries opcode,
//    entry_index and data_value
//  - a write stores data_value at entry_index in the same cycle it is taken;
//    its result (found 0, position 0) shows on the next cycle
//  - a search probes a half-open window over the first active_length entries
//    (at most the table depth), one table read per cycle out of the table memory;
//    the accepting cycle issues the first read address, then each probe compares
//    the registered read data and issues the next address until a hit or an empty window
//  - results: rsp_item is valid for exactly one cycle, flagged by rsp_strobe,
//    which coincides with busy dropping after a probed search; the receiver cannot stall
//  - configuration: csr_we writes csr_wdata into active_length; write it only
//    while the block is idle
//  - reset (synchronous, active high) clears the sequencer, the result strobe
//    and active_length; table contents stay undefined until written, so no
//    clearing pass is run
module sorted_table_binary_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  sts_pkg::req_type          req_item,
   output logic                      busy,
   output logic                      rsp_strobe,
   output sts_pkg::rsp_type          rsp_item,
   input  logic                      csr_we,
   input  logic [sts_pkg::LEN_W-1:0] csr_wdata
);

`include "sorted_table_binary_search_assert.svh"

   // configuration register
   logic [sts_pkg::LEN_W-1:0] active_length_ff, active_length_in;

   // table memory interface
   sts_pkg::mem_req_type       mem_req;
   logic [sts_pkg::DATA_W-1:0] rd_data;

   assign active_length_in = csr_we ? csr_wdata : active_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= '0;
      end else begin
         active_length_ff <= active_length_in;
      end
   end

   // sequencer: window bookkeeping, compare and result register
   sts_search_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_item      (req_item),
      .active_length (active_length_ff),
      .rd_data       (rd_data),
      .busy          (busy),
      .mem_req       (mem_req),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item)
   );

   // table storage, read data registered in the cycle after the address
   sts_table_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // a result only goes out while the sequencer is idle
   `STS_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_strobe, !busy)

   // a write transfer answers on the next cycle with a miss
   `STS_ASSERT_NEXT(a_write_rsp, clock, reset,
                    start && !busy && (req_item.opcode == sts_pkg::OP_WRITE),
                    rsp_strobe && !rsp_item.found)

   // a miss always reports position zero
   `STS_ASSERT_NOW(a_miss_pos_zero, clock, reset,
                   rsp_strobe && !rsp_item.found, rsp_item.position == '0)

   // the search ending means a result in the cycle busy drops
   `STS_ASSERT_NOW(a_done_rsp, clock, reset, $fell(busy), rsp_strobe)

endmodule

[tb/sorted_table_binary_search_checker.sv]
// checker for the sorted table search block: watches request, result and register
// transfers, predicts every answer and compares it field by field
// depends on sts_pkg
module sorted_table_binary_search_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  sts_pkg::req_type          req_item,
   input  logic                      rsp_strobe,
   input  sts_pkg::rsp_type          rsp_item,
   input  logic                      csr_we,
   input  logic [sts_pkg::LEN_W-1:0] csr_wdata,
   output int                        pending_count,
   output int                        mismatch_count,
   output int                        search_count,
   output int                        hit_count,
   output int                        write_count
);
   import sts_pkg::*;

   logic signed [DATA_W-1:0] table_words [TABLE_DEPTH];
   logic [LEN_W-1:0]         search_length;
   rsp_type                  expected_answers [$];
   int                       issued_count;
   int                       answered_count;
   int                       printed_lines;

   // the issued and answered counters move with nonblocking updates so the stimulus side sees settled values
   assign pending_count = issued_count - answered_count;

   // binary search over the copy of the table, half-open window [lo, hi)
   function automatic rsp_type search_answer(logic signed [DATA_W-1:0] key);
      rsp_type answer;
      int      lo;
      int      hi;
      int      mid;
      answer = '0;
      lo = 0;
      hi = (search_length > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_length);
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (table_words[mid[7:0]] == key) begin
            answer.found = 1'b1;
            answer.position = mid[7:0];
            break;
         end
         if (table_words[mid[7:0]] > key) hi = mid;
         else lo = mid + 1;
      end
      return answer;
   endfunction

   task automatic report_mismatch(string what);
      if (printed_lines < 40) $display("[%0t] mismatch: %s", $time, what);
      printed_lines++;
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type wanted;
      if (reset) begin
         expected_answers.delete();
         search_length = '0;
         issued_count <= 0;
         answered_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("result with no transfer outstanding (found %b position %0d)",
                                         rsp_item.found, rsp_item.position));
            end else begin
               wanted = expected_answers.pop_front();
               if (rsp_item.found !== wanted.found)
                  report_mismatch($sformatf("found %b, predicted %b",
                                            rsp_item.found, wanted.found));
               if (rsp_item.position !== wanted.position)
                  report_mismatch($sformatf("position %0d, predicted %0d",
                                            rsp_item.position, wanted.position));
               answered_count <= answered_count + 1;
            end
         end
         if (start && !busy) begin
            if (req_item.opcode == OP_SEARCH) begin
               wanted = search_answer(req_item.data_value);
               search_count++;
               if (wanted.found) hit_count++;
            end else begin
               table_words[req_item.entry_index] = req_item.data_value;
               wanted = '0;
               write_count++;
            end
            expected_answers.push_back(wanted);
            issued_count <= issued_count + 1;
         end
         if (csr_we) search_length = csr_wdata;
      end
   end

endmodule

[tb/tb_sorted_table_binary_search.sv]
// testbench top for the sorted table search block: drives directed and random
// write and search transfers, changes the search length between phases, gives the verdict
// depends on sts_pkg, sorted_table_binary_search and sorted_table_binary_search_checker
module tb_sorted_table_binary_search;
   import sts_pkg::*;

   // the limit leaves a wide margin over the slowest correct run
   localparam int CYCLE_LIMIT = 400_000;
   // percentage of cycles in which the sender holds back
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SPARSE = 14;
   localparam int IDLE_HEAVY  = 78;

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

   logic             clock;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_item  = '0;
   logic             busy;
   logic             rsp_strobe;
   rsp_type          rsp_item;
   logic             csr_we    = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;

   int pending_count;
   int mismatch_count;
   int search_count;
   int hit_count;
   int write_count;
   int cycle_count = 0;

   // stimulus-side picture of the table, used to choose keys near stored words and nearby write values
   logic signed [DATA_W-1:0] shadow_words [TABLE_DEPTH];
   // number of entries a search may touch under the current length
   int search_span = 0;
   int idle_pct    = IDLE_NONE;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   sorted_table_binary_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   sorted_table_binary_search_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count),
      .search_count   (search_count),
      .hit_count      (hit_count),
      .write_count    (write_count)
   );

   // one request transfer; start stays high into the next item unless a gap is drawn
   task automatic send_item(logic op, logic [7:0] idx, logic signed [DATA_W-1:0] value);
      req_type item;
      item.opcode = op;
      item.entry_index = idx;
      item.data_value = value;
      // random sender gap, each idle cycle is its own time step
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      // the transfer happens at the first edge that sees busy low
      do @(posedge clock); while (busy);
      if (op == OP_WRITE) shadow_words[idx] = value;
   endtask

   // hold the sender until every outstanding result has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   // register writes only while the block is idle
   task automatic set_search_length(logic [LEN_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      search_span = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
   endtask

   // fill every entry in ascending order; a zero step now and then makes duplicates
   task automatic load_ascending(longint first, int max_step);
      longint level;
      level = first;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(OP_WRITE, i[7:0], level[DATA_W-1:0]);
         if ($urandom_range(9) != 0) level += longint'($urandom_range(max_step));
         if (level > longint'(WORD_MAX)) level = longint'(WORD_MAX);
      end
   endtask

   // mostly stored words (hits), then near misses, random words and extremes
   function automatic logic signed [DATA_W-1:0] pick_key();
      int                       choice;
      logic signed [DATA_W-1:0] word;
      choice = $urandom_range(99);
      word = shadow_words[8'($urandom_range((search_span > 0) ? search_span - 1 : 0))];
      if (choice < 50) return word;
      if (choice < 70) return ($urandom_range(1) != 0) ? word + 1 : word - 1;
      if (choice < 85) return $urandom;
      case ($urandom_range(3))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // searches with a sprinkling of writes that may break the ascending order
   task automatic random_items(int count, int write_pct);
      logic [7:0] idx;
      for (int n = 0; n < count; n++) begin
         idx = 8'($urandom_range(TABLE_DEPTH - 1));
         if ($urandom_range(99) < write_pct) begin
            if ($urandom_range(1) != 0) send_item(OP_WRITE, idx, $urandom);
            else send_item(OP_WRITE, idx, shadow_words[idx] + $urandom_range(3) - 1);
         end else begin
            // entry_index is ignored on a search, drive it with noise anyway
            send_item(OP_SEARCH, idx, pick_key());
         end
      end
   endtask

   initial begin : stimulus
      foreach (shadow_words[i]) shadow_words[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length: every search misses, nothing is read
      idle_pct = IDLE_SPARSE;
      set_search_length(0);
      send_item(OP_SEARCH, 8'h00, '0);
      send_item(OP_SEARCH, 8'hFF, WORD_MIN);
      send_item(OP_SEARCH, 8'h5A, WORD_MAX);
      // extreme words and indexes
      send_item(OP_WRITE, 8'h00, WORD_MIN);
      send_item(OP_WRITE, 8'h01, WORD_MAX);
      send_item(OP_WRITE, 8'hFF, WORD_MAX);
      send_item(OP_WRITE, 8'h80, -1);

      // two-entry window over words written above
      set_search_length(2);
      send_item(OP_SEARCH, 8'h00, WORD_MIN);
      send_item(OP_SEARCH, 8'h00, WORD_MAX);
      send_item(OP_SEARCH, 8'h00, '0);
      send_item(OP_SEARCH, 8'h00, -1);
      // descending pair: the lower key hits, the upper one is steered away and misses
      send_item(OP_WRITE, 8'h00, 5);
      send_item(OP_WRITE, 8'h01, -5);
      send_item(OP_SEARCH, 8'h00, -5);
      send_item(OP_SEARCH, 8'h00, 5);
      // duplicates: first probe wins, then a two-probe hit at entry zero
      send_item(OP_WRITE, 8'h00, 7);
      send_item(OP_WRITE, 8'h01, 7);
      send_item(OP_SEARCH, 8'h00, 7);
      send_item(OP_WRITE, 8'h01, 9);
      send_item(OP_SEARCH, 8'h00, 7);

      // whole table written from here on, wide spread from min up to clipped max
      idle_pct = IDLE_NONE;
      load_ascending(longint'(WORD_MIN), 33_000_000);

      // full depth with a heavy sender gap; the drain in the middle empties the block
      set_search_length(LEN_W'(TABLE_DEPTH));
      idle_pct = IDLE_HEAVY;
      random_items(150, 5);
      drain();
      random_items(150, 5);

      // length beyond the depth saturates
      set_search_length(511);
      idle_pct = IDLE_SPARSE;
      random_items(150, 5);

      // dense table around zero, many repeated words
      load_ascending(longint'(int'($urandom_range(600)) - 300), 2);

      set_search_length(1);
      idle_pct = IDLE_NONE;
      random_items(60, 5);

      set_search_length(LEN_W'($urandom_range(TABLE_DEPTH - 1, 2)));
      idle_pct = IDLE_HEAVY;
      random_items(290, 8);

      set_search_length(LEN_W'(TABLE_DEPTH));
      idle_pct = IDLE_NONE;
      random_items(200, 5);

      set_search_length(0);
      idle_pct = IDLE_SPARSE;
      random_items(20, 10);

      // wait out the last results plus the longest search
      drain();
      repeat (12) @(posedge clock);

      $display("covered %0d searches (%0d hits) and %0d table writes",
               search_count, hit_count, write_count);
      $display("search lengths 0, 1, 2, random, full depth and saturated; sender gaps none to heavy");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit, also catches results that never arrive
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("Mismatches found");
      $finish;
   end

endmodule
